// File: design/gma_pkg.sv
// Shared types, constants and helpers for the grouped median age block.
package gma_pkg;

  localparam int MAX_RECORDS = 256;
  localparam int CNT_W       = $clog2(MAX_RECORDS + 1);
  localparam int AGE_W       = 7;
  localparam int GROUPS      = 7;
  localparam int GID_W       = 3;

  localparam logic [GID_W-1:0] GID_FIRST = 3'd0;
  localparam logic [GID_W-1:0] GID_LAST  = 3'd6;

  typedef struct packed {
    logic             employed;
    logic             is_male;
    logic [AGE_W-1:0] age;
  } rec_t;

  typedef struct packed {
    logic valid;
    rec_t rec;
  } entry_t;

  // Controls broadcast to every cell of the chain.
  typedef struct packed {
    logic insert;
    logic drain;
    rec_t rec;
  } cell_ctl_t;

  // Controls from the sequencer to the group tracker.
  typedef struct packed {
    logic insert;
    rec_t rec;
    logic start;
    logic drain;
    logic done;
  } sel_ctl_t;

  // Membership in: all, female, male, emp female, unemp female, emp male, unemp male.
  function automatic logic [GROUPS-1:0] group_mask(input rec_t r);
    logic [GROUPS-1:0] m;
    m    = '0;
    m[0] = 1'b1;
    m[1] = !r.is_male;
    m[2] = r.is_male;
    m[3] = !r.is_male && r.employed;
    m[4] = !r.is_male && !r.employed;
    m[5] = r.is_male && r.employed;
    m[6] = r.is_male && !r.employed;
    return m;
  endfunction

endpackage

// File: design/gma_cell.sv
// One cell of the sorted record chain.
module gma_cell
  import gma_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  cell_ctl_t ctl,
  input  entry_t    prev_entry,
  input  logic      prev_gt,
  input  entry_t    next_entry,
  output entry_t    entry,
  output logic      gt
);

  entry_t entry_next;

  // Empty cells count as larger than any age.
  assign gt = !entry.valid || (entry.rec.age > ctl.rec.age);

  always_comb begin
    entry_next = entry;
    if (ctl.insert) begin
      if (prev_gt) begin
        entry_next = prev_entry;
      end else if (gt) begin
        entry_next.valid = 1'b1;
        entry_next.rec   = ctl.rec;
      end
    end else if (ctl.drain) begin
      entry_next = next_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      entry <= '0;
    end else begin
      entry <= entry_next;
    end
  end

endmodule

// File: design/gma_chain.sv
// Row of cells keeping records sorted by age; drains towards cell zero.
module gma_chain
  import gma_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  cell_ctl_t ctl,
  output entry_t    head
);

  entry_t entries [MAX_RECORDS];
  logic   gts     [MAX_RECORDS];

  for (genvar i = 0; i < MAX_RECORDS; i++) begin : g_cell
    entry_t p_entry;
    logic   p_gt;
    entry_t n_entry;

    if (i == 0) begin : g_first
      assign p_entry = '0;
      assign p_gt    = 1'b0;
    end else begin : g_mid
      assign p_entry = entries[i-1];
      assign p_gt    = gts[i-1];
    end

    if (i == MAX_RECORDS - 1) begin : g_end
      assign n_entry = '0;
    end else begin : g_inner
      assign n_entry = entries[i+1];
    end

    gma_cell u_cell (
      .clk        (clk),
      .rst        (rst),
      .ctl        (ctl),
      .prev_entry (p_entry),
      .prev_gt    (p_gt),
      .next_entry (n_entry),
      .entry      (entries[i]),
      .gt         (gts[i])
    );
  end

  assign head = entries[0];

endmodule

// File: design/gma_select.sv
// Per-group counts and upper median capture from the drained stream.
module gma_select
  import gma_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  sel_ctl_t         ctl,
  input  entry_t           head,
  input  logic [GID_W-1:0] gid,
  output logic [AGE_W-1:0] median
);

  logic [CNT_W-1:0] cnt [GROUPS];
  logic [CNT_W-1:0] run [GROUPS];
  logic [AGE_W-1:0] med [GROUPS];
  logic [GROUPS-1:0] ins_mask;
  logic [GROUPS-1:0] head_mask;

  assign ins_mask  = group_mask(ctl.rec);
  assign head_mask = group_mask(head.rec);

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int g = 0; g < GROUPS; g++) begin
        cnt[g] <= '0;
        run[g] <= '0;
        med[g] <= '0;
      end
    end else begin
      for (int g = 0; g < GROUPS; g++) begin
        if (ctl.done) begin
          cnt[g] <= '0;
        end else if (ctl.insert && ins_mask[g]) begin
          cnt[g] <= cnt[g] + 1'b1;
        end
        if (ctl.start) begin
          run[g] <= '0;
          med[g] <= '0;
        end else if (ctl.drain && head.valid && head_mask[g]) begin
          if (run[g] == (cnt[g] >> 1)) begin
            med[g] <= head.rec.age;
          end
          run[g] <= run[g] + 1'b1;
        end
      end
    end
  end

  assign median = med[gid];

endmodule

// File: design/grouped_median_age.sv
// Top level of the grouped median age block: load, drain and report sequencer.
//
// Usage:
//   Request channel: present age, is_male, employed and last_record with start
//   high; the request is taken at a rising edge where start is high and busy
//   is low. Records load at one per cycle while busy is low into a row of
//   cells that keeps them sorted by age, up to MAX_RECORDS records; further
//   records are dropped and flagged on records_dropped.
//   A request with last_record high is loaded like any other and then starts
//   the run: busy rises, the chain drains one record per cycle past the group
//   tracker, a hand-over step then passes to the report, and seven results
//   follow on consecutive cycles, one per group: all, female, male, employed
//   female, unemployed female, employed male, unemployed male.
//   Result channel: strobe marks each result for exactly one cycle; the
//   receiver cannot stall, so results leave at the pace shown. end_of_run
//   marks the seventh. The last result shows in the first cycle after busy
//   falls, so the next set may load at once.
//   Reset (rst, synchronous) empties every cell, clears counts and the drop
//   flag, and returns the block to loading.
module grouped_median_age
  import gma_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  output logic             busy,
  input  logic [AGE_W-1:0] age,
  input  logic             is_male,
  input  logic             employed,
  input  logic             last_record,
  output logic             strobe,
  output logic [GID_W-1:0] group_id,
  output logic [AGE_W-1:0] median_age,
  output logic             records_dropped,
  output logic             end_of_run
);

  typedef enum logic [1:0] {
    S_LOAD,
    S_DRAIN,
    S_EMIT
  } state_t;

  state_t           state;
  logic [CNT_W-1:0] count;
  logic             overflow;
  logic [GID_W-1:0] gid;

  logic      accept;
  logic      has_room;
  rec_t      in_rec;
  cell_ctl_t cell_ctl;
  sel_ctl_t  sel_ctl;
  entry_t    head;
  logic [AGE_W-1:0] sel_median;

  assign busy     = (state != S_LOAD);
  assign accept   = start && !busy;
  assign has_room = (count < CNT_W'(MAX_RECORDS));

  assign in_rec.age      = age;
  assign in_rec.is_male  = is_male;
  assign in_rec.employed = employed;

  // Insert only while room is left; drain shifts the row towards cell zero.
  assign cell_ctl.insert = accept && has_room;
  assign cell_ctl.drain  = (state == S_DRAIN) && (count != '0);
  assign cell_ctl.rec    = in_rec;

  assign sel_ctl.insert = cell_ctl.insert;
  assign sel_ctl.rec    = in_rec;
  assign sel_ctl.start  = accept && last_record;
  assign sel_ctl.drain  = cell_ctl.drain;
  assign sel_ctl.done   = (state == S_EMIT) && (gid == GID_LAST);

  gma_chain u_chain (
    .clk  (clk),
    .rst  (rst),
    .ctl  (cell_ctl),
    .head (head)
  );

  gma_select u_select (
    .clk    (clk),
    .rst    (rst),
    .ctl    (sel_ctl),
    .head   (head),
    .gid    (gid),
    .median (sel_median)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= S_LOAD;
      count           <= '0;
      overflow        <= 1'b0;
      gid             <= GID_FIRST;
      strobe          <= 1'b0;
      group_id        <= GID_FIRST;
      median_age      <= '0;
      records_dropped <= 1'b0;
      end_of_run      <= 1'b0;
    end else begin
      strobe     <= 1'b0;
      end_of_run <= 1'b0;
      unique case (state)
        S_LOAD: begin
          if (accept) begin
            // Store the request, or drop it and flag the set.
            if (has_room) begin
              count <= count + 1'b1;
            end else begin
              overflow <= 1'b1;
            end
            if (last_record) begin
              state <= S_DRAIN;
            end
          end
        end
        S_DRAIN: begin
          // Advance one record per cycle past the tracker until empty.
          if (count != '0) begin
            count <= count - 1'b1;
          end else begin
            gid   <= GID_FIRST;
            state <= S_EMIT;
          end
        end
        S_EMIT: begin
          strobe          <= 1'b1;
          group_id        <= gid;
          median_age      <= sel_median;
          records_dropped <= overflow;
          end_of_run      <= (gid == GID_LAST);
          if (gid == GID_LAST) begin
            overflow <= 1'b0;
            gid      <= GID_FIRST;
            state    <= S_LOAD;
          end else begin
            gid <= gid + 1'b1;
          end
        end
        default: begin
          state <= S_LOAD;
        end
      endcase
    end
  end

endmodule

// File: design/gma_checker.sv
// Port-level checks for the grouped median age block, bound to the top level.
module gma_checker
  import gma_pkg::*;
(
  input logic             clk,
  input logic             rst,
  input logic             start,
  input logic             busy,
  input logic             last_record,
  input logic             strobe,
  input logic [GID_W-1:0] group_id,
  input logic             end_of_run
);

  a_eor_last: assert property (@(posedge clk) disable iff (rst)
    strobe |-> (end_of_run == (group_id == GID_LAST)))
    else $error("end_of_run does not match the last group");

  a_gid_step: assert property (@(posedge clk) disable iff (rst)
    (strobe && !end_of_run) |=> (strobe && (group_id == $past(group_id) + 3'd1)))
    else $error("results of a run are not consecutive");

  a_busy_emit: assert property (@(posedge clk) disable iff (rst)
    (strobe && !end_of_run) |-> busy)
    else $error("result shown while not busy");

  a_run_start: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && last_record) |=> (busy && !strobe))
    else $error("last request did not start a run");

endmodule

bind grouped_median_age gma_checker u_gma_checker (
  .clk         (clk),
  .rst         (rst),
  .start       (start),
  .busy        (busy),
  .last_record (last_record),
  .strobe      (strobe),
  .group_id    (group_id),
  .end_of_run  (end_of_run)
);
